@@ design/tokdf_pkg.sv @@
// Package for the token record deframer: phase encoding, field and error codes,
// configuration register indexes, reset values and the result beat structure.
// No dependencies.
package tokdf_pkg;

  // Parse phase; the encoding doubles as the field kind of the byte taken.
  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_VALUE   = 3'd1,
    PH_SLEN    = 3'd2,
    PH_STAMP   = 3'd3,
    PH_KEYID   = 3'd4,
    PH_TOKID   = 3'd5,
    PH_BNCOUNT = 3'd6,
    PH_BNBODY  = 3'd7
  } phase_t;

  localparam logic [3:0] KIND_NONE = 4'd8;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_RANGE   = 3'd1;
  localparam logic [2:0] ERR_STAMP   = 3'd2;
  localparam logic [2:0] ERR_TYPE    = 3'd3;
  localparam logic [2:0] ERR_TRUNC   = 3'd4;
  localparam logic [2:0] ERR_BIGNUM  = 3'd5;
  localparam logic [2:0] ERR_DISCARD = 3'd6;

  localparam logic [7:0] TYPE_REUSABLE = 8'd1;
  localparam logic [7:0] TYPE_HASHCASH = 8'd2;

  localparam logic [1:0] CFG_VALUE_MIN   = 2'd0;
  localparam logic [1:0] CFG_VALUE_MAX   = 2'd1;
  localparam logic [1:0] CFG_MAX_STAMP   = 2'd2;
  localparam logic [1:0] CFG_MAX_BIGNUM  = 2'd3;

  localparam logic [7:0]  RST_VALUE_MIN  = 8'd20;
  localparam logic [7:0]  RST_VALUE_MAX  = 8'd50;
  localparam logic [15:0] RST_MAX_STAMP  = 16'd1024;
  localparam logic [15:0] RST_MAX_BIGNUM = 16'd256;

  // Bytes in the value field and in each length field.
  localparam logic [15:0] WORD_BYTES = 16'd4;

  // One result beat.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  field_kind;
    logic [7:0]  record_type;
    logic [7:0]  record_value;
    logic [15:0] section_length;
    logic        record_done;
    logic [2:0]  error_code;
  } res_t;

endpackage

@@ design/token_record_deframer.sv @@
// Token record deframer top level: parser state, configuration registers and
// a two-entry output stage. Depends on tokdf_pkg.
//
// Usage. Input beats carry one stream byte (data_byte) or an end marker
// (end_marker high, no byte). Each input beat gives exactly one result beat
// that tags the byte with its field kind, the record type and value, the
// current section length, a record-complete flag and an error code.
// After an error every byte is tagged as discarded until an end marker,
// which always returns the parser to the start of a record.
// Configuration beats on the cfg channel write value_min, value_max,
// max_stamp_length and max_bignum_length by index; cfg_ready is always high,
// and writes are meant to land only while the block is idle.
// A result is registered in the output register, or in the skid register while
// the output register holds an untaken result. Throughput is one beat per cycle
// while results are taken, set by the single parser state update per byte. The
// output register is backed by a skid register, so one more input beat is taken
// while a result waits; in_ready drops only once both are full and recovers the
// cycle after the receiver takes a beat. Synchronous reset empties the output
// stage, returns the parser to the start of a record and resets the registers.
module token_record_deframer #(
  parameter int KEY_ID_BYTES   = 20,
  parameter int TOKEN_ID_BYTES = 34
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_marker,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [3:0]  field_kind,
  output logic [7:0]  record_type,
  output logic [7:0]  record_value,
  output logic [15:0] section_length,
  output logic        record_done,
  output logic [2:0]  error_code,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tokdf_pkg::*;

  localparam logic [15:0] KeyLast   = 16'(KEY_ID_BYTES);
  localparam logic [15:0] TokenLast = 16'(TOKEN_ID_BYTES);

  // Configuration registers.
  logic [7:0]  value_min;
  logic [7:0]  value_max;
  logic [15:0] max_stamp_length;
  logic [15:0] max_bignum_length;

  // Parser state. Value and length keep their low bits plus a flag that
  // records whether any higher byte of the 32-bit word was non-zero.
  phase_t      phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] len_low, len_low_next;
  logic        len_hi, len_hi_next;
  logic [7:0]  type_held, type_held_next;
  logic [7:0]  val_low, val_low_next;
  logic        val_hi, val_hi_next;
  logic        discard, discard_next;

  // Output stage.
  res_t        res;
  res_t        out_reg;
  res_t        skid_reg;
  logic        skid_valid;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      value_min         <= RST_VALUE_MIN;
      value_max         <= RST_VALUE_MAX;
      max_stamp_length  <= RST_MAX_STAMP;
      max_bignum_length <= RST_MAX_BIGNUM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VALUE_MIN:  value_min         <= cfg_data[7:0];
        CFG_VALUE_MAX:  value_max         <= cfg_data[7:0];
        CFG_MAX_STAMP:  max_stamp_length  <= cfg_data;
        CFG_MAX_BIGNUM: max_bignum_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Parser step for the beat on the input channel.
  always_comb begin
    logic [15:0] cnt_inc;
    logic        val_shift_hi;
    logic        len_shift_hi;
    logic [15:0] len_shift;
    logic [15:0] lim;
    cnt_inc      = byte_count + 16'd1;
    val_shift_hi = val_hi || (val_low != 8'd0);
    len_shift_hi = len_hi || (len_low[15:8] != 8'd0);
    len_shift    = {len_low[7:0], data_byte};
    lim          = (phase == PH_SLEN) ? max_stamp_length : max_bignum_length;

    phase_next      = phase;
    byte_count_next = byte_count;
    len_low_next    = len_low;
    len_hi_next     = len_hi;
    type_held_next  = type_held;
    val_low_next    = val_low;
    val_hi_next     = val_hi;
    discard_next    = discard;

    res.out_byte       = data_byte;
    res.field_kind     = KIND_NONE;
    res.record_type    = type_held;
    res.record_value   = 8'd0;
    res.section_length = 16'd0;
    res.record_done    = 1'b0;
    res.error_code     = ERR_NONE;

    if (end_marker) begin
      // End of stream: flag truncation inside a record, then start afresh.
      res.out_byte    = 8'd0;
      res.error_code  = (!discard && phase != PH_TYPE) ? ERR_TRUNC : ERR_NONE;
      phase_next      = PH_TYPE;
      byte_count_next = 16'd0;
      len_low_next    = 16'd0;
      len_hi_next     = 1'b0;
      type_held_next  = 8'd0;
      val_low_next    = 8'd0;
      val_hi_next     = 1'b0;
      discard_next    = 1'b0;
    end else if (discard) begin
      res.error_code = ERR_DISCARD;
    end else begin
      res.field_kind = {1'b0, phase};
      case (phase)
        PH_TYPE: begin
          type_held_next  = data_byte;
          val_low_next    = 8'd0;
          val_hi_next     = 1'b0;
          byte_count_next = 16'd0;
          phase_next      = PH_VALUE;
        end
        PH_VALUE: begin
          val_low_next    = data_byte;
          val_hi_next     = val_shift_hi;
          byte_count_next = cnt_inc;
          if (cnt_inc >= WORD_BYTES) begin
            // Range is checked before the type.
            byte_count_next = 16'd0;
            len_low_next    = 16'd0;
            len_hi_next     = 1'b0;
            if (val_shift_hi || data_byte < value_min || data_byte > value_max) begin
              res.error_code = ERR_RANGE;
            end else if (type_held == TYPE_HASHCASH) begin
              phase_next = PH_SLEN;
            end else if (type_held == TYPE_REUSABLE) begin
              phase_next = PH_KEYID;
            end else begin
              res.error_code = ERR_TYPE;
            end
            res.record_value = data_byte;
          end
        end
        PH_SLEN, PH_BNCOUNT: begin
          res.record_value = val_low;
          len_low_next     = len_shift;
          len_hi_next      = len_shift_hi;
          byte_count_next  = cnt_inc;
          if (cnt_inc >= WORD_BYTES) begin
            byte_count_next = 16'd0;
            if (len_shift_hi || len_shift > lim) begin
              res.error_code = (phase == PH_SLEN) ? ERR_STAMP : ERR_BIGNUM;
            end else begin
              res.section_length = len_shift;
              if (len_shift == 16'd0) begin
                // An empty section completes the record at once.
                res.record_done = 1'b1;
                phase_next      = PH_TYPE;
              end else begin
                phase_next = (phase == PH_SLEN) ? PH_STAMP : PH_BNBODY;
              end
            end
          end
        end
        PH_STAMP, PH_BNBODY: begin
          res.record_value   = val_low;
          res.section_length = len_low;
          byte_count_next    = cnt_inc;
          if (cnt_inc >= len_low) begin
            byte_count_next = 16'd0;
            res.record_done = 1'b1;
            phase_next      = PH_TYPE;
          end
        end
        PH_KEYID: begin
          res.record_value = val_low;
          byte_count_next  = cnt_inc;
          if (cnt_inc >= KeyLast) begin
            byte_count_next = 16'd0;
            phase_next      = PH_TOKID;
          end
        end
        PH_TOKID: begin
          res.record_value = val_low;
          byte_count_next  = cnt_inc;
          if (cnt_inc >= TokenLast) begin
            byte_count_next = 16'd0;
            len_low_next    = 16'd0;
            len_hi_next     = 1'b0;
            phase_next      = PH_BNCOUNT;
          end
        end
        default: begin
          res.field_kind  = KIND_NONE;
          phase_next      = PH_TYPE;
          byte_count_next = 16'd0;
        end
      endcase
      // An error clears the payload fields and starts discarding next byte.
      if (res.error_code != ERR_NONE) begin
        discard_next       = 1'b1;
        res.record_value   = 8'd0;
        res.section_length = 16'd0;
      end
      res.record_type = type_held_next;
    end
  end

  // Parser state registers, advanced on each accepted input beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      byte_count <= 16'd0;
      len_low    <= 16'd0;
      len_hi     <= 1'b0;
      type_held  <= 8'd0;
      val_low    <= 8'd0;
      val_hi     <= 1'b0;
      discard    <= 1'b0;
    end else if (in_fire) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      len_low    <= len_low_next;
      len_hi     <= len_hi_next;
      type_held  <= type_held_next;
      val_low    <= val_low_next;
      val_hi     <= val_hi_next;
      discard    <= discard_next;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (in_fire) begin
        out_reg <= res;
      end
    end else if (in_fire) begin
      skid_reg <= res;
    end
  end

  assign out_byte       = out_reg.out_byte;
  assign field_kind     = out_reg.field_kind;
  assign record_type    = out_reg.record_type;
  assign record_value   = out_reg.record_value;
  assign section_length = out_reg.section_length;
  assign record_done    = out_reg.record_done;
  assign error_code     = out_reg.error_code;

  // The skid register only fills behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a beat while the output register is empty");

  // A completed record never carries an error.
  a_done_no_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_done) |-> (error_code == ERR_NONE))
    else $error("record completion reported together with an error");

  // Discarded bytes are never tagged with a field.
  a_discard_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == ERR_DISCARD) |-> (field_kind == KIND_NONE))
    else $error("discarded byte tagged with a field kind");

  // An end marker always returns the parser to the start of a record.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_marker) |=> (phase == PH_TYPE && !discard && byte_count == 16'd0))
    else $error("parser not at record start after an end marker");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for token_record_deframer: a directed stimulus table, then
// random record streams over several register settings, each result beat checked
// against the table or an in-bench parser model. Depends on tokdf_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb_top;
  import tokdf_pkg::*;

  localparam int KEY_BYTES    = 20;
  localparam int TOKEN_BYTES  = 34;
  localparam int PHASE_BEATS  = 250;
  localparam int DIR_ROWS     = 25;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 40;

  // One input beat, and one row of the directed table.
  typedef struct packed {
    logic [7:0] b;
    logic       em;
  } beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       em;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_marker;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic [3:0]  field_kind;
  logic [7:0]  record_type;
  logic [7:0]  record_value;
  logic [15:0] section_length;
  logic        record_done;
  logic [2:0]  error_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  token_record_deframer #(
    .KEY_ID_BYTES   (KEY_BYTES),
    .TOKEN_ID_BYTES (TOKEN_BYTES)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_marker     (end_marker),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .field_kind     (field_kind),
    .record_type    (record_type),
    .record_value   (record_value),
    .section_length (section_length),
    .record_done    (record_done),
    .error_code     (error_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Parser model state and its copy of the registers.
  phase_t      pr_phase;
  int unsigned pr_count;
  logic [31:0] pr_len;
  logic [7:0]  pr_type;
  logic [31:0] pr_value;
  logic        pr_discard;
  logic [7:0]  lim_vmin;
  logic [7:0]  lim_vmax;
  logic [15:0] lim_stamp;
  logic [15:0] lim_bignum;

  res_t        tag_q[$];
  beat_t       rec_q[$];
  dir_row_t    dir_tab[DIR_ROWS];

  int unsigned cycles = 0;
  int          mismatches = 0;
  int          beats_in = 0;
  int          results_seen = 0;
  int          records_done = 0;
  int          error_tags = 0;
  int          settings_run = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, reckoned well above the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic clear_parser();
    pr_phase   = PH_TYPE;
    pr_count   = 0;
    pr_len     = '0;
    pr_type    = '0;
    pr_value   = '0;
    pr_discard = 1'b0;
  endtask

  // Tags one byte or end marker and advances the parser model.
  task automatic deframe_byte(input logic [7:0] b, input logic em, output res_t r);
    logic [2:0]  err;
    logic [7:0]  rval;
    logic [31:0] slen;
    logic [31:0] lim;
    logic        done;
    logic [3:0]  kind;
    err  = ERR_NONE;
    rval = '0;
    slen = '0;
    done = 1'b0;
    kind = KIND_NONE;
    if (em) begin
      // An end marker only reports truncation when a record was under way.
      if (!pr_discard && pr_phase != PH_TYPE) err = ERR_TRUNC;
      r.out_byte       = 8'h00;
      r.field_kind     = KIND_NONE;
      r.record_type    = pr_type;
      r.record_value   = 8'h00;
      r.section_length = 16'h0000;
      r.record_done    = 1'b0;
      r.error_code     = err;
      clear_parser();
    end else begin
      if (pr_discard) begin
        err = ERR_DISCARD;
      end else begin
        kind = {1'b0, pr_phase};
        case (pr_phase)
          PH_TYPE: begin
            pr_type  = b;
            pr_value = '0;
            pr_count = 0;
            pr_phase = PH_VALUE;
          end
          PH_VALUE: begin
            pr_value = {pr_value[23:0], b};
            pr_count++;
            // Range is judged before the type on the last value byte.
            if (pr_count >= WORD_BYTES) begin
              pr_count = 0;
              pr_len   = '0;
              if (pr_value < lim_vmin || pr_value > lim_vmax) err = ERR_RANGE;
              else if (pr_type == TYPE_HASHCASH) pr_phase = PH_SLEN;
              else if (pr_type == TYPE_REUSABLE) pr_phase = PH_KEYID;
              else err = ERR_TYPE;
              if (err == ERR_NONE) rval = pr_value[7:0];
            end
          end
          PH_SLEN, PH_BNCOUNT: begin
            rval   = pr_value[7:0];
            pr_len = {pr_len[23:0], b};
            pr_count++;
            if (pr_count >= WORD_BYTES) begin
              lim      = (pr_phase == PH_SLEN) ? {16'h0000, lim_stamp} :
                                                 {16'h0000, lim_bignum};
              pr_count = 0;
              if (pr_len > lim) begin
                err = (pr_phase == PH_SLEN) ? ERR_STAMP : ERR_BIGNUM;
              end else begin
                slen = pr_len;
                // A zero length closes the record on its last length byte.
                if (pr_len == 0) begin
                  done     = 1'b1;
                  pr_phase = PH_TYPE;
                end else begin
                  pr_phase = (pr_phase == PH_SLEN) ? PH_STAMP : PH_BNBODY;
                end
              end
            end
          end
          PH_STAMP, PH_BNBODY: begin
            rval = pr_value[7:0];
            slen = pr_len;
            pr_count++;
            if (pr_count >= pr_len) begin
              pr_count = 0;
              done     = 1'b1;
              pr_phase = PH_TYPE;
            end
          end
          PH_KEYID: begin
            rval = pr_value[7:0];
            pr_count++;
            if (pr_count >= KEY_BYTES) begin
              pr_count = 0;
              pr_phase = PH_TOKID;
            end
          end
          PH_TOKID: begin
            rval = pr_value[7:0];
            pr_count++;
            if (pr_count >= TOKEN_BYTES) begin
              pr_count = 0;
              pr_len   = '0;
              pr_phase = PH_BNCOUNT;
            end
          end
          default: ;
        endcase
        if (err != ERR_NONE) begin
          pr_discard = 1'b1;
          rval       = '0;
          slen       = '0;
        end
      end
      r.out_byte       = b;
      r.field_kind     = kind;
      r.record_type    = pr_type;
      r.record_value   = rval;
      r.section_length = slen[15:0];
      r.record_done    = done;
      r.error_code     = err;
    end
  endtask

  function automatic dir_row_t mk_row(input logic [7:0] b);
    dir_row_t row;
    row       = '0;
    row.b     = b;
    return row;
  endfunction

  // Rows whose result is plain to see: end markers and error bytes.
  function automatic dir_row_t mk_exp(input logic [7:0] b, input logic em,
                                      input logic [3:0] kind, input logic [7:0] rtype,
                                      input logic [2:0] err);
    dir_row_t row;
    row                  = '0;
    row.b                = b;
    row.em               = em;
    row.typed            = 1'b1;
    row.want.out_byte    = em ? 8'h00 : b;
    row.want.field_kind  = kind;
    row.want.record_type = rtype;
    row.want.error_code  = err;
    return row;
  endfunction

  // Sends one input beat in bursts with random gaps, then logs its expected tag.
  task automatic send_beat(input logic [7:0] b, input logic em, input logic typed,
                           input res_t want);
    res_t pred;
    int   gap;
    if (burst_left == 0) begin
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    data_byte  <= b;
    end_marker <= em;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b, em, pred);
    tag_q.push_back(typed ? want : pred);
    beats_in++;
  endtask

  // Holds the input back until every outstanding tag has come out.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tag_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_VALUE_MIN:  lim_vmin   = val[7:0];
      CFG_VALUE_MAX:  lim_vmax   = val[7:0];
      CFG_MAX_STAMP:  lim_stamp  = val;
      CFG_MAX_BIGNUM: lim_bignum = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    beat_t bt;
    bt.b  = b;
    bt.em = 1'b0;
    rec_q.push_back(bt);
  endtask

  task automatic add_word(input logic [31:0] w);
    add_byte(w[31:24]);
    add_byte(w[23:16]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endtask

  task automatic add_end();
    beat_t bt;
    bt.b  = 8'h00;
    bt.em = 1'b1;
    rec_q.push_back(bt);
  endtask

  // Mostly values inside the window; the rest miss it by the low or high bytes.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 85 && lim_vmin <= lim_vmax)
      return $urandom_range(lim_vmin, lim_vmax);
    if ($urandom_range(0, 1) == 1) return $urandom | 32'h0000_0100;
    if (lim_vmin > 0) return $urandom_range(0, lim_vmin - 1);
    if (lim_vmax < 255) return $urandom_range(lim_vmax + 1, 255);
    return $urandom | 32'h0100_0000;
  endfunction

  // Short sections mostly, the limit itself when it is small, and some over it.
  function automatic logic [31:0] pick_length(input logic [15:0] lim);
    logic [31:0] l32;
    int          pick;
    l32  = {16'h0000, lim};
    pick = $urandom_range(0, 99);
    if (pick < 10) return 32'd0;
    if (pick < 75) return $urandom_range(0, (l32 < 40) ? l32 : 40);
    if (pick < 82 && l32 <= 300) return l32;
    if (pick < 92) return l32 + 32'd1 + $urandom_range(0, 2);
    return $urandom | 32'h0001_0000;
  endfunction

  // Builds one record with random content, sometimes broken or cut short.
  task automatic send_record();
    logic [7:0]  rtype;
    logic [31:0] val;
    logic [31:0] len;
    logic        bad;
    int          pick;
    int          cut;
    beat_t       bt;
    rec_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 45) rtype = TYPE_HASHCASH;
    else if (pick < 85) rtype = TYPE_REUSABLE;
    else rtype = 8'($urandom);
    add_byte(rtype);
    val = pick_value();
    add_word(val);
    bad = (val < lim_vmin) || (val > lim_vmax) ||
          (rtype != TYPE_HASHCASH && rtype != TYPE_REUSABLE);
    if (!bad) begin
      if (rtype == TYPE_REUSABLE) begin
        repeat (KEY_BYTES + TOKEN_BYTES) add_byte(8'($urandom));
        len = pick_length(lim_bignum);
        bad = len > lim_bignum;
      end else begin
        len = pick_length(lim_stamp);
        bad = len > lim_stamp;
      end
      add_word(len);
      if (!bad) repeat (len) add_byte(8'($urandom));
    end
    // A broken record leaves the parser discarding until an end marker.
    if (bad) begin
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
      add_end();
    end else if ($urandom_range(0, 99) < 8) begin
      cut = $urandom_range(1, rec_q.size() - 1);
      while (rec_q.size() > cut) void'(rec_q.pop_back());
      add_end();
    end else if ($urandom_range(0, 4) == 0) begin
      add_end();
    end
    while (rec_q.size() != 0) begin
      bt = rec_q.pop_front();
      send_beat(bt.b, bt.em, 1'b0, '0);
    end
  endtask

  // One register setting: written while idle, then a stretch of random records.
  task automatic run_setting(input logic [7:0] vmin, input logic [7:0] vmax,
                             input logic [15:0] stamp_lim, input logic [15:0] bn_lim,
                             input bit steady);
    int start;
    bit paused;
    drain();
    write_reg(CFG_VALUE_MIN, {8'h00, vmin});
    write_reg(CFG_VALUE_MAX, {8'h00, vmax});
    write_reg(CFG_MAX_STAMP, stamp_lim);
    write_reg(CFG_MAX_BIGNUM, bn_lim);
    steady_send = steady;
    settings_run++;
    start  = beats_in;
    paused = 1'b0;
    while (beats_in < start + PHASE_BEATS) begin
      send_record();
      if (!paused && beats_in >= start + PHASE_BEATS / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    steady_send = 1'b0;
  endtask

  // Receiver: free-running, random stalls, or long stall runs, switched in spans.
  initial begin : sink_stall
    int mode;
    int span;
    int hold;
    out_ready = 1'b0;
    hold      = 0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(50, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) >= 4);
          default: begin
            if (hold > 0) begin
              out_ready <= 1'b0;
              hold--;
            end else begin
              out_ready <= 1'b1;
              hold = $urandom_range(1, 8);
            end
          end
        endcase
      end
    end
  end

  task automatic check_field(input string fname, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Result beats are compared field by field with the oldest expected tag.
  always @(posedge clk) begin : tag_check
    res_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (record_done === 1'b1) records_done++;
      if (error_code !== ERR_NONE) error_tags++;
      if (tag_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result beat with nothing expected, byte %0h", $time, out_byte);
        mismatches++;
      end else begin
        want = tag_q.pop_front();
        check_field("out_byte", {8'h00, want.out_byte}, {8'h00, out_byte});
        check_field("field_kind", {12'h000, want.field_kind}, {12'h000, field_kind});
        check_field("record_type", {8'h00, want.record_type}, {8'h00, record_type});
        check_field("record_value", {8'h00, want.record_value}, {8'h00, record_value});
        check_field("section_length", want.section_length, section_length);
        check_field("record_done", {15'h0000, want.record_done}, {15'h0000, record_done});
        check_field("error_code", {13'h0000, want.error_code}, {13'h0000, error_code});
      end
    end
  end

  initial begin : main_seq
    dir_row_t row;
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = 8'h00;
    end_marker = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_VALUE_MIN;
    cfg_data   = 16'h0000;
    lim_vmin   = RST_VALUE_MIN;
    lim_vmax   = RST_VALUE_MAX;
    lim_stamp  = RST_MAX_STAMP;
    lim_bignum = RST_MAX_BIGNUM;
    clear_parser();

    // Directed rows under the reset register values (window 20 to 50).
    // End marker straight after reset.
    dir_tab[0]  = mk_exp(8'h00, 1'b1, KIND_NONE, 8'h00, ERR_NONE);
    // Hashcash record at the bottom of the window with an empty stamp.
    dir_tab[1]  = mk_row(TYPE_HASHCASH);
    dir_tab[2]  = mk_row(8'h00);
    dir_tab[3]  = mk_row(8'h00);
    dir_tab[4]  = mk_row(8'h00);
    dir_tab[5]  = mk_row(8'h14);
    dir_tab[6]  = mk_row(8'h00);
    dir_tab[7]  = mk_row(8'h00);
    dir_tab[8]  = mk_row(8'h00);
    dir_tab[9]  = mk_row(8'h00);
    // Unknown type at the top of the window, then a discarded byte.
    dir_tab[10] = mk_row(8'hFF);
    dir_tab[11] = mk_row(8'h00);
    dir_tab[12] = mk_row(8'h00);
    dir_tab[13] = mk_row(8'h00);
    dir_tab[14] = mk_exp(8'h32, 1'b0, {1'b0, PH_VALUE}, 8'hFF, ERR_TYPE);
    dir_tab[15] = mk_exp(8'hFF, 1'b0, KIND_NONE, 8'hFF, ERR_DISCARD);
    dir_tab[16] = mk_exp(8'h00, 1'b1, KIND_NONE, 8'hFF, ERR_NONE);
    // Value far out of range through its top byte.
    dir_tab[17] = mk_row(TYPE_HASHCASH);
    dir_tab[18] = mk_row(8'hFF);
    dir_tab[19] = mk_row(8'h00);
    dir_tab[20] = mk_row(8'h00);
    dir_tab[21] = mk_exp(8'h33, 1'b0, {1'b0, PH_VALUE}, TYPE_HASHCASH, ERR_RANGE);
    dir_tab[22] = mk_exp(8'h00, 1'b1, KIND_NONE, TYPE_HASHCASH, ERR_NONE);
    // Reusable record cut short by an end marker.
    dir_tab[23] = mk_row(TYPE_REUSABLE);
    dir_tab[24] = mk_exp(8'h00, 1'b1, KIND_NONE, TYPE_REUSABLE, ERR_TRUNC);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      send_beat(row.b, row.em, row.typed, row.want);
    end

    // Random records under the reset values, then the extremes and a few others.
    begin
      int start;
      start = beats_in;
      settings_run++;
      while (beats_in < start + PHASE_BEATS) send_record();
    end
    run_setting(8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 1'b1);
    run_setting(8'd0, 8'd0, 16'h0000, 16'h0000, 1'b0);
    run_setting(8'd200, 8'd10, 16'd16, 16'd16, 1'b0);
    run_setting(8'd255, 8'd255, 16'd1, 16'd2, 1'b0);
    begin
      logic [7:0] rmin;
      rmin = 8'($urandom_range(0, 255));
      run_setting(rmin, 8'($urandom_range(rmin, 255)), 16'($urandom), 16'($urandom),
                  1'b0);
    end

    // Wind down: let every expected tag arrive, then a short settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (tag_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("tb_top: %0d input beats over %0d register settings, %0d results checked",
             beats_in, settings_run, results_seen);
    $display("tb_top: %0d records completed, %0d beats tagged with an error or discard",
             records_done, error_tags);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
